// ===== hw/rtl/x86ild_pkg.sv =====
`timescale 1ns / 1ps
package x86ild_pkg;

  typedef enum logic [2:0] {
    PH_PREFIX = 3'd0,
    PH_OPC    = 3'd1,
    PH_OPC2   = 3'd2,
    PH_MODRM  = 3'd3,
    PH_SIB    = 3'd4,
    PH_TAIL   = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    ST_PENDING  = 2'd0,
    ST_COMPLETE = 2'd1,
    ST_FAIL     = 2'd2
  } status_e;

  localparam logic [7:0] F_MODRM = 8'h01;
  localparam logic [7:0] F_IMM8  = 8'h02;
  localparam logic [7:0] F_IMM16 = 8'h04;
  localparam logic [7:0] F_IMMZ  = 8'h08;
  localparam logic [7:0] F_REL8  = 8'h10;
  localparam logic [7:0] F_REL32 = 8'h20;
  localparam logic [7:0] F_MOVI  = 8'h40;
  localparam logic [7:0] F_SUP   = 8'h80;

  localparam logic [7:0] OP_ESC   = 8'h0F;
  localparam logic [7:0] PFX_OPSZ = 8'h66;
  localparam logic [7:0] PFX_ADSZ = 8'h67;
  localparam logic [7:0] OP_RET   = 8'hC3;
  localparam logic [7:0] OP_RETI  = 8'hC2;
  localparam logic [7:0] OP_GRP3B = 8'hF6;
  localparam logic [7:0] OP_GRP3V = 8'hF7;
  localparam logic [7:0] REX_LO   = 8'h40;
  localparam logic [7:0] REX_HI   = 8'h4F;

  // Result item, packed highest field first.
  typedef struct packed {
    logic [8:0] prologue_length;
    logic       prologue_done;
    logic [2:0] rel_size;
    logic [7:0] rel_offset;
    logic       has_rel_branch;
    logic [7:0] rip_disp_offset;
    logic       has_rip_relative;
    logic       is_return;
    logic [7:0] instr_length;
    logic       instr_valid;
  } result_t;

  function automatic logic [7:0] one_byte_flags(input logic [7:0] op);
    logic [7:0] f;
    f = 8'h00;
    if (op < 8'h40) begin
      if (op[2:0] <= 3'd3) f = F_SUP | F_MODRM;
      else if (op[2:0] == 3'd4) f = F_SUP | F_IMM8;
      else if (op[2:0] == 3'd5) f = F_SUP | F_IMMZ;
    end else if (op >= 8'h50 && op <= 8'h5F) f = F_SUP;
    else if (op >= 8'h70 && op <= 8'h7F) f = F_SUP | F_REL8;
    else if (op >= 8'h84 && op <= 8'h8B) f = F_SUP | F_MODRM;
    else if (op >= 8'h90 && op <= 8'h99) f = F_SUP;
    else if (op >= 8'hB0 && op <= 8'hB7) f = F_SUP | F_IMM8;
    else if (op >= 8'hB8 && op <= 8'hBF) f = F_SUP | F_MOVI;
    else if (op >= 8'hD0 && op <= 8'hD3) f = F_SUP | F_MODRM;
    else begin
      case (op)
        8'h63, 8'h8D, 8'h8F, 8'hF6, 8'hF7, 8'hFE, 8'hFF: f = F_SUP | F_MODRM;
        8'h68, 8'hA9: f = F_SUP | F_IMMZ;
        8'h69, 8'h81, 8'hC7: f = F_SUP | F_MODRM | F_IMMZ;
        8'h6A, 8'hA8: f = F_SUP | F_IMM8;
        8'h6B, 8'h80, 8'h83, 8'hC0, 8'hC1, 8'hC6: f = F_SUP | F_MODRM | F_IMM8;
        8'h9C, 8'h9D, 8'hC3, 8'hC9, 8'hCC, 8'hF5, 8'hF8, 8'hF9, 8'hFC, 8'hFD:
          f = F_SUP;
        8'hC2: f = F_SUP | F_IMM16;
        8'hE8, 8'hE9: f = F_SUP | F_REL32;
        8'hEB: f = F_SUP | F_REL8;
        default: f = 8'h00;
      endcase
    end
    return f;
  endfunction

  function automatic logic [7:0] two_byte_flags(input logic [7:0] op);
    logic [7:0] f;
    f = 8'h00;
    if ((op >= 8'h10 && op <= 8'h1F) || (op >= 8'h28 && op <= 8'h2F) ||
        (op >= 8'h40 && op <= 8'h4F) || (op >= 8'h51 && op <= 8'h6F) ||
        (op >= 8'h74 && op <= 8'h7F) || (op >= 8'h90 && op <= 8'h9F) ||
        (op >= 8'hD0 && op <= 8'hFE) || (op >= 8'hBB && op <= 8'hC1))
      f = F_SUP | F_MODRM;
    else if (op >= 8'h70 && op <= 8'h73) f = F_SUP | F_MODRM | F_IMM8;
    else if (op >= 8'h80 && op <= 8'h8F) f = F_SUP | F_REL32;
    else begin
      case (op)
        8'h05, 8'h0B, 8'hA2: f = F_SUP;
        8'hA3, 8'hA5, 8'hAB, 8'hAD, 8'hAF, 8'hB0, 8'hB1, 8'hB3, 8'hB6, 8'hB7:
          f = F_SUP | F_MODRM;
        8'hA4, 8'hAC, 8'hBA, 8'hC6: f = F_SUP | F_MODRM | F_IMM8;
        default: f = 8'h00;
      endcase
    end
    return f;
  endfunction

  function automatic logic is_legacy_prefix(input logic [7:0] b);
    return b == 8'h26 || b == 8'h2E || b == 8'h36 || b == 8'h3E ||
           b == 8'h64 || b == 8'h65 || b == PFX_OPSZ || b == PFX_ADSZ ||
           b == 8'hF0 || b == 8'hF2 || b == 8'hF3;
  endfunction

endpackage

// ===== hw/rtl/x86_64_instruction_length_decoder_top.sv =====
`timescale 1ns / 1ps
// x86-64 instruction length decoder. Feed code bytes one item per cycle on the
// s_axis side, tlast marking the buffer's final byte; one result item comes out
// on m_axis for each finished or failed instruction. A byte accepted into the input
// register is decoded by the core, which loads the result register, and the result
// item then moves into the output buffer, from which it is offered on m_axis.
// Throughput is one byte per cycle when nothing stalls: each byte passes one table
// lookup and counter update between the input register and the result register. A
// two-entry output buffer sits behind the result register, so s_axis_tready_o
// depends on registered state only; when the buffer is full the result register
// holds, then the input register holds and tready drops. Once the prologue measure
// finishes, bytes up to the next tlast give no result. The user must write min_length
// (reset 5, 0 acts as 1) via cfg_valid_i/cfg_data_i only while idle; not enforced.
module x86_64_instruction_length_decoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,          // min_length
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,      // code_byte
  input  logic        s_axis_tlast_i,      // last_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o       // instr_valid, instr_length, is_return,
                                           // has_rip_relative, rip_disp_offset,
                                           // has_rel_branch, rel_offset, rel_size,
                                           // prologue_done, prologue_length, pad
);
  import x86ild_pkg::*;

  logic [7:0] minl_q;
  logic       in_v_q, in_l_q;
  logic [7:0] in_b_q;
  logic       res_v;
  result_t    res;
  result_t    buf_q [2];
  logic [1:0] cnt_q;
  logic       rd_q, wr_q;
  logic       push, pop;
  logic       res_free, step;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) minl_q <= 8'd5;
    else if (cfg_valid_i) minl_q <= cfg_data_i;
  end

  // Move the result register into the buffer while there is room; the result
  // register is free when empty or moving, and the core steps only then.
  assign push     = res_v && (cnt_q != 2'd2);
  assign res_free = !res_v || push;
  assign step     = in_v_q && res_free;

  // Take a new item when the input register is empty or being consumed.
  assign s_axis_tready_o = !in_v_q || res_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) in_v_q <= 1'b0;
    else if (s_axis_tready_o) in_v_q <= s_axis_tvalid_i;
  end

  // Hold the byte while it waits for the core.
  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o) begin
      in_b_q <= s_axis_tdata_i;
      in_l_q <= s_axis_tlast_i;
    end
  end

  x86ild_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (in_b_q),
    .last_i      (in_l_q),
    .min_length_i(minl_q),
    .res_ready_i (res_free),
    .res_valid_o (res_v),
    .res_o       (res)
  );

  assign pop = m_axis_tvalid_o && m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; rd_q <= 1'b0; wr_q <= 1'b0;
    end else begin
      if (push) wr_q <= !wr_q;
      if (pop) rd_q <= !rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wr_q] <= res;
  end

  assign m_axis_tvalid_o = cnt_q != 2'd0;
  assign m_axis_tdata_o  = {7'd0, buf_q[rd_q]};

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2) |-> !push) else $error("result buffer overflow");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("result count out of range");
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_v && !push) |=> (res_v && $stable(res))) else $error("waiting result lost");
`endif
endmodule

// ===== hw/rtl/x86ild_core.sv =====
`timescale 1ns / 1ps
module x86ild_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          byte_i,
  input  logic                last_i,
  input  logic [7:0]          min_length_i,
  input  logic                res_ready_i,
  output logic                res_valid_o,
  output x86ild_pkg::result_t res_o
);
  import x86ild_pkg::*;

  phase_e      phase_q, phase_d;
  logic [7:0]  count_q, count_d;
  logic [3:0]  skip_q, skip_d;
  logic [7:0]  flags_q, flags_d;
  logic [7:0]  opc_q, opc_d;
  logic        opsz_q, opsz_d, adsz_q, adsz_d, rexw_q, rexw_d, two_q, two_d;
  logic [8:0]  total_q, total_d;
  logic        fin_q, fin_d;
  logic [1:0]  mode_q, mode_d;
  logic        ret_q, ret_d, rip_q, rip_d, rel_q, rel_d;
  logic [7:0]  ripoff_q, ripoff_d, reloff_q, reloff_d;
  logic [2:0]  relsz_q, relsz_d;

  status_e     st;
  logic [7:0]  fl, cnt;
  logic        tail_go;
  logic [2:0]  disp;
  logic [3:0]  imm;
  logic [7:0]  minl;
  logic [8:0]  sum;
  logic        reached, done;
  result_t     res;
  logic        emit;

  always_comb begin
    phase_d = phase_q; count_d = count_q; skip_d = skip_q; flags_d = flags_q;
    opc_d = opc_q; opsz_d = opsz_q; adsz_d = adsz_q; rexw_d = rexw_q;
    two_d = two_q; total_d = total_q; fin_d = fin_q; mode_d = mode_q;
    ret_d = ret_q; rip_d = rip_q; rel_d = rel_q; ripoff_d = ripoff_q;
    reloff_d = reloff_q; relsz_d = relsz_q;
    st = ST_PENDING; fl = 8'h00; tail_go = 1'b0; disp = 3'd0; imm = 4'd0;
    cnt = count_q + 8'd1;
    minl = (min_length_i == 8'd0) ? 8'd1 : min_length_i;
    sum = 9'd0; reached = 1'b0; done = 1'b0; res = '0; emit = 1'b0;

    if (step_i && !fin_q) begin
      if (count_q == 8'd255) st = ST_FAIL;
      else begin
        count_d = cnt;
        fl = flags_q;
        case (phase_q)
          PH_PREFIX, PH_OPC, PH_OPC2: begin
            if (phase_q == PH_PREFIX && is_legacy_prefix(byte_i)) begin
              if (byte_i == PFX_OPSZ) opsz_d = 1'b1;
              if (byte_i == PFX_ADSZ) adsz_d = 1'b1;
            end else if (phase_q == PH_PREFIX && byte_i >= REX_LO && byte_i <= REX_HI) begin
              rexw_d = byte_i[3];
              phase_d = PH_OPC;
            end else if (phase_q != PH_OPC2 && byte_i == OP_ESC) begin
              two_d = 1'b1;
              phase_d = PH_OPC2;
            end else begin
              if (phase_q == PH_OPC2) fl = two_byte_flags(byte_i);
              else begin
                fl = one_byte_flags(byte_i);
                ret_d = (byte_i == OP_RET || byte_i == OP_RETI);
              end
              if ((fl & F_SUP) == 8'h00) st = ST_FAIL;
              else begin
                opc_d = byte_i;
                flags_d = fl;
                if ((fl & F_MODRM) != 8'h00) phase_d = PH_MODRM;
                else tail_go = 1'b1;
              end
            end
          end
          PH_MODRM: begin
            mode_d = byte_i[7:6];
            if (!two_q && byte_i[5:3] <= 3'd1) begin
              if (opc_q == OP_GRP3B) fl = fl | F_IMM8;
              if (opc_q == OP_GRP3V) fl = fl | F_IMMZ;
            end
            flags_d = fl;
            if (byte_i[7:6] != 2'd3 && byte_i[2:0] == 3'd4) phase_d = PH_SIB;
            else begin
              tail_go = 1'b1;
              if (byte_i[7:6] == 2'd0 && byte_i[2:0] == 3'd5) begin
                rip_d = !adsz_q;
                ripoff_d = cnt;
                disp = 3'd4;
              end else if (byte_i[7:6] == 2'd1) disp = 3'd1;
              else if (byte_i[7:6] == 2'd2) disp = 3'd4;
            end
          end
          PH_SIB: begin
            tail_go = 1'b1;
            if (mode_q == 2'd0 && byte_i[2:0] == 3'd5) disp = 3'd4;
            else if (mode_q == 2'd1) disp = 3'd1;
            else if (mode_q == 2'd2) disp = 3'd4;
          end
          PH_TAIL: begin
            if (skip_q == 4'd0) st = ST_COMPLETE;
            else begin
              skip_d = skip_q - 4'd1;
              if (skip_d == 4'd0) st = ST_COMPLETE;
            end
          end
          default: st = ST_FAIL;
        endcase

        if (tail_go) begin
          if ((fl & F_MOVI) != 8'h00) imm = imm + (rexw_q ? 4'd8 : (opsz_q ? 4'd2 : 4'd4));
          if ((fl & F_IMM8) != 8'h00) imm = imm + 4'd1;
          if ((fl & F_IMM16) != 8'h00) imm = imm + 4'd2;
          if ((fl & F_IMMZ) != 8'h00) imm = imm + (opsz_q ? 4'd2 : 4'd4);
          skip_d = {1'b0, disp} + imm;
          if ((fl & F_REL8) != 8'h00) begin
            rel_d = 1'b1; reloff_d = cnt + {5'd0, disp} + {4'd0, imm}; relsz_d = 3'd1;
            skip_d = skip_d + 4'd1;
          end
          if ((fl & F_REL32) != 8'h00) begin
            rel_d = 1'b1; reloff_d = cnt + {5'd0, disp} + {4'd0, imm}; relsz_d = 3'd4;
            skip_d = skip_d + 4'd4;
          end
          phase_d = PH_TAIL;
          if (skip_d == 4'd0) st = ST_COMPLETE;
        end
      end

      if (st == ST_PENDING && last_i) st = ST_FAIL;

      if (st != ST_PENDING) begin
        emit = 1'b1;
        if (st == ST_FAIL) begin
          res.prologue_done = 1'b1;
          done = 1'b1;
        end else begin
          sum = total_q + {1'b0, count_d};
          reached = sum >= {1'b0, minl};
          done = ret_d || reached || last_i;
          total_d = sum;
          res.instr_valid = 1'b1;
          res.instr_length = count_d;
          res.is_return = ret_d;
          res.has_rip_relative = rip_d;
          res.rip_disp_offset = ripoff_d;
          res.has_rel_branch = rel_d;
          res.rel_offset = reloff_d;
          res.rel_size = relsz_d;
          res.prologue_done = done;
          res.prologue_length = (done && reached) ? sum : 9'd0;
        end
        // Clear per-instruction state.
        phase_d = PH_PREFIX; count_d = '0; skip_d = '0; flags_d = '0; opc_d = '0;
        opsz_d = 1'b0; adsz_d = 1'b0; rexw_d = 1'b0; two_d = 1'b0; mode_d = '0;
        ret_d = 1'b0; rip_d = 1'b0; rel_d = 1'b0; ripoff_d = '0; reloff_d = '0;
        relsz_d = '0;
        if (done) fin_d = 1'b1;
      end
      if (last_i) begin
        total_d = '0;
        fin_d = 1'b0;
      end
    end else if (step_i && fin_q && last_i) begin
      fin_d = 1'b0;
      total_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_PREFIX; count_q <= '0; skip_q <= '0; flags_q <= '0;
      opc_q <= '0; opsz_q <= 1'b0; adsz_q <= 1'b0; rexw_q <= 1'b0; two_q <= 1'b0;
      total_q <= '0; fin_q <= 1'b0; mode_q <= '0; ret_q <= 1'b0; rip_q <= 1'b0;
      rel_q <= 1'b0; ripoff_q <= '0; reloff_q <= '0; relsz_q <= '0;
      res_valid_o <= 1'b0;
    end else begin
      phase_q <= phase_d; count_q <= count_d; skip_q <= skip_d; flags_q <= flags_d;
      opc_q <= opc_d; opsz_q <= opsz_d; adsz_q <= adsz_d; rexw_q <= rexw_d;
      two_q <= two_d; total_q <= total_d; fin_q <= fin_d; mode_q <= mode_d;
      ret_q <= ret_d; rip_q <= rip_d; rel_q <= rel_d; ripoff_q <= ripoff_d;
      reloff_q <= reloff_d; relsz_q <= relsz_d;
      if (res_ready_i) res_valid_o <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) res_o <= res;
  end

`ifndef SYNTHESIS
  a_skip_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skip_q != 4'd0) |-> (phase_q == PH_TAIL)) else $error("skip outside tail");
  a_fin_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q |-> (count_q == 8'd0 && phase_q == PH_PREFIX)) else $error("skip with open instr");
  a_emit_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> (count_q == 8'd0)) else $error("count not cleared");
`endif
endmodule
